>>> sv/assert_macros.svh
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/kvtc_pkg.sv
package kvtc_pkg;

    localparam int IDX_W  = 12;
    localparam int CNT_W  = 13;
    localparam int VCNT_W = 9;
    localparam int WORD_W = 64;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DROP_IDX,
        OP_DROP_OLD,
        OP_INSERT,
        OP_UPDATE
    } op_e_t;

    typedef enum logic [1:0] {
        CMD_VOTE  = 2'd0,
        CMD_FIND  = 2'd1,
        CMD_ERASE = 2'd2
    } cmd_e_t;

    typedef enum logic [0:0] {
        REG_VOTER_LIMIT = 1'b0,
        REG_ENTRY_LIMIT = 1'b1
    } reg_e_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_INSERT,
        ST_VREAD,
        ST_VCHECK,
        ST_APPLY,
        ST_TRIM,
        ST_OUT
    } state_e_t;

    // Command broadcast to every cell
    typedef struct packed {
        op_e_t              op;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   age;
        logic [CNT_W-1:0]   cnt;
        logic [WORD_W-1:0]  key;
        logic [WORD_W-1:0]  tally;
        logic [WORD_W-1:0]  final_sum;
        logic [VCNT_W-1:0]  voters;
    } bcast_t;

    // Lookup token handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic [WORD_W-1:0]  key;
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic [CNT_W-1:0]   hit_age;
        logic [WORD_W-1:0]  hit_tally;
        logic [WORD_W-1:0]  hit_final;
        logic [VCNT_W-1:0]  hit_voters;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
        logic               old_found;
        logic [IDX_W-1:0]   old_idx;
    } probe_t;

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
    endfunction

endpackage

>>> sv/kvtc_cell.sv
module kvtc_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [kvtc_pkg::IDX_W-1:0] cell_id,
    input  kvtc_pkg::bcast_t           bcast,
    input  kvtc_pkg::probe_t           probe_in,
    output kvtc_pkg::probe_t           probe_out,
    output logic                       valid_out
);

    logic                          valid_reg;
    logic [kvtc_pkg::WORD_W-1:0]   key_reg;
    logic [kvtc_pkg::WORD_W-1:0]   tally_reg;
    logic [kvtc_pkg::WORD_W-1:0]   final_reg;
    logic [kvtc_pkg::VCNT_W-1:0]   voters_reg;
    logic [kvtc_pkg::CNT_W-1:0]    age_reg;
    kvtc_pkg::probe_t              probe_reg;
    kvtc_pkg::probe_t              probe_next;
    logic                          me;
    logic                          is_old;

    assign me     = (bcast.idx == cell_id);
    assign is_old = valid_reg && (age_reg == bcast.cnt - kvtc_pkg::CNT_W'(1));

    always_comb begin
        probe_next = probe_in;
        if (probe_in.valid) begin
            if (valid_reg && key_reg == probe_in.key) begin
                probe_next.hit        = 1'b1;
                probe_next.hit_idx    = cell_id;
                probe_next.hit_age    = age_reg;
                probe_next.hit_tally  = tally_reg;
                probe_next.hit_final  = final_reg;
                probe_next.hit_voters = voters_reg;
            end
            if (!valid_reg && !probe_in.free_found) begin
                probe_next.free_found = 1'b1;
                probe_next.free_idx   = cell_id;
            end
            if (is_old) begin
                probe_next.old_found = 1'b1;
                probe_next.old_idx   = cell_id;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            probe_reg <= '0;
        end else begin
            probe_reg <= probe_next;
            case (bcast.op)
                kvtc_pkg::OP_DROP_IDX: if (me) valid_reg <= 1'b0;
                kvtc_pkg::OP_DROP_OLD: if (is_old) valid_reg <= 1'b0;
                kvtc_pkg::OP_INSERT:   if (me) valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (bcast.op)
            kvtc_pkg::OP_DROP_IDX: begin
                if (!me && valid_reg && age_reg > bcast.age)
                    age_reg <= age_reg - kvtc_pkg::CNT_W'(1);
            end
            kvtc_pkg::OP_INSERT: begin
                if (me) begin
                    key_reg    <= bcast.key;
                    tally_reg  <= '0;
                    final_reg  <= '0;
                    voters_reg <= '0;
                    age_reg    <= '0;
                end else if (valid_reg) begin
                    age_reg <= age_reg + kvtc_pkg::CNT_W'(1);
                end
            end
            kvtc_pkg::OP_UPDATE: begin
                if (me) begin
                    tally_reg  <= bcast.tally;
                    final_reg  <= bcast.final_sum;
                    voters_reg <= bcast.voters;
                end
            end
            default: ;
        endcase
    end

    assign probe_out = probe_reg;
    assign valid_out = valid_reg;

endmodule

>>> sv/keyed_vote_tally_cache_top.sv
// Channel  | Direction | Contents
// s_       | in        | tuser: command[1:0]; tdata: key, voter, time, weight
// m_       | out       | tuser: ok; tdata: tally, final tally, voter count
// cfg_     | in        | register index, write data
// A lookup token walks the row of cells one cell a cycle, then DECIDE runs.
// A vote inserts on a miss, reads stored voters (VREAD, VCHECK) to a match or the end,
// then goes APPLY, TRIM past the entry limit, and OUT; find and erase go to OUT.
// One item is in flight at a time; a held result does not block the next input beat.
// Reset (aresetn low, synchronous) clears all entries at once; no clearing pass.
`include "assert_macros.svh"

module keyed_vote_tally_cache_top #(
    parameter int CACHE_ENTRIES    = 64,
    parameter int VOTERS_PER_ENTRY = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // block_key, voter_id, vote_time, voter_weight
    input  logic [1:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // tally_out, final_tally_out, voter_count_out, pad
    output logic         m_tuser,   // ok
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [6:0]   cfg_data
);

    localparam int MEM_DEPTH = CACHE_ENTRIES * VOTERS_PER_ENTRY;
    localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int IW  = kvtc_pkg::IDX_W;
    localparam int CW  = kvtc_pkg::CNT_W;
    localparam int VW  = kvtc_pkg::VCNT_W;
    localparam int WW  = kvtc_pkg::WORD_W;

    kvtc_pkg::state_e_t state_reg, state_next;

    logic [4:0]    voter_limit_reg;
    logic [6:0]    entry_limit_reg;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [1:0]    cmd_reg, cmd_next;
    logic [WW-1:0] key_reg, key_next;
    logic [WW-1:0] voter_reg, voter_next;
    logic [WW-1:0] time_reg, time_next;
    logic [WW-1:0] weight_reg, weight_next;

    kvtc_pkg::probe_t pr_reg, pr_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [WW-1:0] tally_reg, tally_next;
    logic [WW-1:0] final_reg, final_next;
    logic [VW-1:0] n_reg, n_next;
    logic [VW-1:0] v_reg, v_next;
    logic          miss_reg, miss_next;
    logic          replaced_reg, replaced_next;

    logic          res_ok_reg, res_ok_next;
    logic [WW-1:0] res_tally_reg, res_tally_next;
    logic [WW-1:0] res_final_reg, res_final_next;
    logic [4:0]    res_cnt_reg, res_cnt_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [135:0]  m_tdata_reg, m_tdata_next;
    logic          m_tuser_reg, m_tuser_next;

    logic [2*WW-1:0] vmem [MEM_DEPTH];
    logic [2*WW-1:0] rd_reg;
    logic            mem_we;
    logic [MAW-1:0]  mem_addr;
    logic [2*WW-1:0] mem_wdata;

    kvtc_pkg::bcast_t bcast;
    kvtc_pkg::probe_t probe_chain [CACHE_ENTRIES+1];
    logic [CACHE_ENTRIES-1:0] valid_vec;

    logic [VW-1:0] lim;
    logic          s_acc;
    logic          is_final;

    assign s_acc     = s_tvalid && s_tready;
    assign s_tready  = (state_reg == kvtc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign lim = (VW'(voter_limit_reg) > VW'(VOTERS_PER_ENTRY)) ?
                 VW'(VOTERS_PER_ENTRY) : VW'(voter_limit_reg);
    assign is_final = (time_reg == {WW{1'b1}});
    assign mem_addr = MAW'(int'(slot_reg) * VOTERS_PER_ENTRY + int'(v_reg));

    always_comb begin
        probe_chain[0]       = '0;
        probe_chain[0].valid = s_acc;
        probe_chain[0].key   = s_tdata[63:0];
    end

    generate
        for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
            kvtc_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cell_id   (IW'(i)),
                .bcast     (bcast),
                .probe_in  (probe_chain[i]),
                .probe_out (probe_chain[i+1]),
                .valid_out (valid_vec[i])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (mem_we) vmem[mem_addr] <= mem_wdata;
        rd_reg <= vmem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= kvtc_pkg::ST_IDLE;
            voter_limit_reg <= 5'd16;
            entry_limit_reg <= 7'd64;
            cnt_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    kvtc_pkg::REG_VOTER_LIMIT: voter_limit_reg <= cfg_data[4:0];
                    kvtc_pkg::REG_ENTRY_LIMIT: entry_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        voter_reg     <= voter_next;
        time_reg      <= time_next;
        weight_reg    <= weight_next;
        pr_reg        <= pr_next;
        slot_reg      <= slot_next;
        tally_reg     <= tally_next;
        final_reg     <= final_next;
        n_reg         <= n_next;
        v_reg         <= v_next;
        miss_reg      <= miss_next;
        replaced_reg  <= replaced_next;
        res_ok_reg    <= res_ok_next;
        res_tally_reg <= res_tally_next;
        res_final_reg <= res_final_next;
        res_cnt_reg   <= res_cnt_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        voter_next     = voter_reg;
        time_next      = time_reg;
        weight_next    = weight_reg;
        pr_next        = pr_reg;
        slot_next      = slot_reg;
        tally_next     = tally_reg;
        final_next     = final_reg;
        n_next         = n_reg;
        v_next         = v_reg;
        miss_next      = miss_reg;
        replaced_next  = replaced_reg;
        res_ok_next    = res_ok_reg;
        res_tally_next = res_tally_reg;
        res_final_next = res_final_reg;
        res_cnt_next   = res_cnt_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        mem_we         = 1'b0;
        mem_wdata      = {voter_reg, time_reg};
        bcast          = '0;
        bcast.op       = kvtc_pkg::OP_NONE;
        bcast.idx      = slot_reg;
        bcast.cnt      = cnt_reg;
        bcast.key      = key_reg;
        bcast.tally    = tally_reg;
        bcast.final_sum = final_reg;
        bcast.voters   = n_reg;

        case (state_reg)
            kvtc_pkg::ST_IDLE: begin
                if (s_acc) begin
                    cmd_next    = s_tuser;
                    key_next    = s_tdata[63:0];
                    voter_next  = s_tdata[127:64];
                    time_next   = s_tdata[191:128];
                    weight_next = s_tdata[255:192];
                    state_next  = kvtc_pkg::ST_SCAN;
                end
            end
            kvtc_pkg::ST_SCAN: begin
                if (probe_chain[CACHE_ENTRIES].valid) begin
                    pr_next    = probe_chain[CACHE_ENTRIES];
                    state_next = kvtc_pkg::ST_DECIDE;
                end
            end
            kvtc_pkg::ST_DECIDE: begin
                res_ok_next    = 1'b0;
                res_tally_next = '0;
                res_final_next = '0;
                res_cnt_next   = '0;
                miss_next      = 1'b0;
                replaced_next  = 1'b0;
                v_next         = '0;
                state_next     = kvtc_pkg::ST_OUT;
                case (cmd_reg)
                    kvtc_pkg::CMD_VOTE: begin
                        if (pr_reg.hit) begin
                            slot_next  = pr_reg.hit_idx;
                            tally_next = pr_reg.hit_tally;
                            final_next = pr_reg.hit_final;
                            n_next     = pr_reg.hit_voters;
                            state_next = kvtc_pkg::ST_VREAD;
                        end else begin
                            miss_next = 1'b1;
                            if (pr_reg.free_found) begin
                                slot_next = pr_reg.free_idx;
                            end else begin
                                // full: replace the oldest
                                slot_next     = pr_reg.old_idx;
                                replaced_next = 1'b1;
                                bcast.op      = kvtc_pkg::OP_DROP_OLD;
                                cnt_next      = cnt_reg - CW'(1);
                            end
                            state_next = kvtc_pkg::ST_INSERT;
                        end
                    end
                    kvtc_pkg::CMD_FIND: begin
                        res_ok_next    = pr_reg.hit;
                        res_tally_next = pr_reg.hit ? pr_reg.hit_tally : '0;
                        res_final_next = pr_reg.hit ? pr_reg.hit_final : '0;
                        res_cnt_next   = pr_reg.hit ? pr_reg.hit_voters[4:0] : '0;
                    end
                    kvtc_pkg::CMD_ERASE: begin
                        if (pr_reg.hit) begin
                            bcast.op    = kvtc_pkg::OP_DROP_IDX;
                            bcast.idx   = pr_reg.hit_idx;
                            bcast.age   = pr_reg.hit_age;
                            cnt_next    = cnt_reg - CW'(1);
                            res_ok_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            kvtc_pkg::ST_INSERT: begin
                bcast.op   = kvtc_pkg::OP_INSERT;
                cnt_next   = cnt_reg + CW'(1);
                tally_next = '0;
                final_next = '0;
                n_next     = '0;
                state_next = kvtc_pkg::ST_VREAD;
            end
            kvtc_pkg::ST_VREAD: begin
                if (v_reg == n_reg) begin
                    // unseen voter: append if room
                    if (n_reg < lim) begin
                        mem_we      = 1'b1;
                        n_next      = n_reg + VW'(1);
                        tally_next  = kvtc_pkg::sat_add(tally_reg, weight_reg);
                        if (is_final)
                            final_next = kvtc_pkg::sat_add(final_reg, weight_reg);
                        res_ok_next = 1'b1;
                    end else begin
                        res_ok_next = 1'b0;
                    end
                    state_next = kvtc_pkg::ST_APPLY;
                end else begin
                    state_next = kvtc_pkg::ST_VCHECK;
                end
            end
            kvtc_pkg::ST_VCHECK: begin
                if (rd_reg[2*WW-1:WW] == voter_reg) begin
                    if (time_reg > rd_reg[WW-1:0]) begin
                        mem_we = 1'b1;
                        if (is_final)
                            final_next = kvtc_pkg::sat_add(final_reg, weight_reg);
                        res_ok_next = 1'b1;
                    end else begin
                        res_ok_next = 1'b0;
                    end
                    state_next = kvtc_pkg::ST_APPLY;
                end else begin
                    v_next     = v_reg + VW'(1);
                    state_next = kvtc_pkg::ST_VREAD;
                end
            end
            kvtc_pkg::ST_APPLY: begin
                bcast.op       = kvtc_pkg::OP_UPDATE;
                res_tally_next = tally_reg;
                res_final_next = final_reg;
                res_cnt_next   = n_reg[4:0];
                if (miss_reg && !replaced_reg && cnt_reg > CW'(entry_limit_reg))
                    state_next = kvtc_pkg::ST_TRIM;
                else
                    state_next = kvtc_pkg::ST_OUT;
            end
            kvtc_pkg::ST_TRIM: begin
                bcast.op = kvtc_pkg::OP_DROP_OLD;
                cnt_next = cnt_reg - CW'(1);
                // the new entry is the oldest only when it stands alone
                if (cnt_reg == CW'(1)) begin
                    res_tally_next = '0;
                    res_final_next = '0;
                    res_cnt_next   = '0;
                end
                state_next = kvtc_pkg::ST_OUT;
            end
            kvtc_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_ok_reg;
                    m_tdata_next  = {3'b000, res_cnt_reg, res_final_reg, res_tally_reg};
                    state_next    = kvtc_pkg::ST_IDLE;
                end
            end
            default: state_next = kvtc_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_NOW(a_cnt_matches_cells, aclk, aresetn, state_reg == kvtc_pkg::ST_IDLE,
        int'(cnt_reg) == $countones(valid_vec), "entry count differs from valid cells")
    `ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1,
        int'(cnt_reg) <= CACHE_ENTRIES, "entry count above capacity")
    `ASSERT_NOW(a_token_in_scan, aclk, aresetn, probe_chain[CACHE_ENTRIES].valid,
        state_reg == kvtc_pkg::ST_SCAN, "lookup token arrived outside scan")
    `ASSERT_NEXT(a_accept_scan, aclk, aresetn, s_tvalid && s_tready,
        state_reg == kvtc_pkg::ST_SCAN, "accepted beat did not start a scan")

endmodule
